FILE: rtl/core/otc_pkg.sv
// shared types, codes and constants of the oscillator trim calibrator
`default_nettype none

package otc_pkg;

	// field and counter widths
	localparam int unsigned TRIM_W     = 8;
	localparam int unsigned DEV_W      = 16;
	localparam int unsigned ERR_W      = 16;
	localparam int unsigned WCNT_W     = 5;
	localparam int unsigned APB_ADDR_W = 4;
	localparam int unsigned APB_DATA_W = 32;

	// register indexes
	localparam logic [1:0] REG_RANGE_MODE  = 2'd0;
	localparam logic [1:0] REG_MAX_STEP    = 2'd1;
	localparam logic [1:0] REG_LOW_SWITCH  = 2'd2;
	localparam logic [1:0] REG_HIGH_SWITCH = 2'd3;

	// range modes, any other code behaves as full range
	localparam logic [1:0] MODE_FULL = 2'd0;
	localparam logic [1:0] MODE_LOW  = 2'd1;
	localparam logic [1:0] MODE_DUAL = 2'd2;

	// register reset values
	localparam logic [1:0]        RST_RANGE_MODE  = MODE_FULL;
	localparam logic [TRIM_W-1:0] RST_MAX_STEP    = 8'd32;
	localparam logic [6:0]        RST_LOW_SWITCH  = 7'd96;
	localparam logic [TRIM_W-1:0] RST_HIGH_SWITCH = 8'd128;

	// input actions
	localparam logic ACT_START  = 1'b0;
	localparam logic ACT_REPORT = 1'b1;

	// trim constants
	localparam logic [TRIM_W-1:0] TRIM_MID      = 8'h80;
	localparam logic [TRIM_W-1:0] TRIM_LOW_TOP  = 8'h7f;
	localparam logic [TRIM_W-1:0] TRIM_MAX      = 8'hff;
	localparam logic [TRIM_W-1:0] SCAN_SPAN     = 8'd2;
	localparam logic [DEV_W-1:0]  DEV_MAX       = 16'hffff;

	// writes sent straight out; later ones collapse into one held write
	localparam logic [WCNT_W-1:0] WRITE_DIRECT = 5'd30;

	typedef enum logic [1:0] {
		KIND_WRITE   = 2'd0,
		KIND_MEASURE = 2'd1,
		KIND_DONE    = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_SEARCH = 2'd1,
		PH_SCAN   = 2'd2
	} phase_t;

	// what follows the end of a trim walk
	typedef enum logic [1:0] {
		CONT_MEAS   = 2'd0,
		CONT_DONE   = 2'd1,
		CONT_FINISH = 2'd2
	} cont_t;

	typedef enum logic [2:0] {
		ST_IDLE       = 3'd0,
		ST_DECODE     = 3'd1,
		ST_BEGIN      = 3'd2,
		ST_FINISH     = 3'd3,
		ST_WALK_SETUP = 3'd4,
		ST_WALK       = 3'd5,
		ST_FLUSH      = 3'd6,
		ST_FINAL      = 3'd7
	} seq_state_t;

	typedef struct packed {
		logic [1:0]        range_mode;
		logic [TRIM_W-1:0] max_step;
		logic [6:0]        low_switch_point;
		logic [TRIM_W-1:0] high_switch_point;
	} cfg_t;

	typedef struct packed {
		logic                    action;
		logic [TRIM_W-1:0]       initial_trim;
		logic signed [ERR_W-1:0] freq_error;
	} in_item_t;

	typedef struct packed {
		kind_t             kind;
		logic [TRIM_W-1:0] trim;
		logic [DEV_W-1:0]  best_deviation;
		logic              last;
	} out_item_t;

endpackage

`default_nettype wire

FILE: rtl/core/otc_regs.sv
// configuration register file on the apb-style port
`default_nettype none

module otc_regs import otc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	cfg_t       cfg_q;
	logic [1:0] reg_idx;
	logic       wr_en;

	assign reg_idx = paddr[APB_ADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite && pready;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.range_mode        <= RST_RANGE_MODE;
			cfg_q.max_step          <= RST_MAX_STEP;
			cfg_q.low_switch_point  <= RST_LOW_SWITCH;
			cfg_q.high_switch_point <= RST_HIGH_SWITCH;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_RANGE_MODE:  cfg_q.range_mode        <= pwdata[1:0];
				REG_MAX_STEP:    cfg_q.max_step          <= pwdata[TRIM_W-1:0];
				REG_LOW_SWITCH:  cfg_q.low_switch_point  <= pwdata[6:0];
				REG_HIGH_SWITCH: cfg_q.high_switch_point <= pwdata[TRIM_W-1:0];
			endcase
		end
	end

	// read mux
	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_RANGE_MODE:  prdata = APB_DATA_W'(cfg_q.range_mode);
			REG_MAX_STEP:    prdata = APB_DATA_W'(cfg_q.max_step);
			REG_LOW_SWITCH:  prdata = APB_DATA_W'(cfg_q.low_switch_point);
			REG_HIGH_SWITCH: prdata = APB_DATA_W'(cfg_q.high_switch_point);
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/core/otc_engine.sv
// calibration sequencer with the shared trim step unit
`default_nettype none

module otc_engine import otc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_item,
	output logic      res_valid,
	input  logic      res_ready,
	output out_item_t res_item
);

	seq_state_t        state_q, state_d;
	phase_t            phase_q;
	cont_t             cont_q;
	kind_t             fkind_q;
	in_item_t          in_q;
	logic [TRIM_W-1:0] cur_q, step_q, trial_q, scan_lo_q, scan_hi_q, best_q;
	logic [TRIM_W-1:0] frt_q, wtgt_q, worig_q, pend_q;
	logic [DEV_W-1:0]  least_q, frd_q, fdev_q;
	logic              ri_q, pend_v_q;
	logic [WCNT_W-1:0] wcnt_q;

	// mirror a switch point onto the other range's switch point
	function automatic logic [TRIM_W-1:0] mirror(input cfg_t c, input logic [TRIM_W-1:0] t);
		return TRIM_W'({1'b0, c.low_switch_point}) + c.high_switch_point - t;
	endfunction

	// report decode
	logic              is_dual, is_low, err_zero, err_neg;
	logic [ERR_W-1:0]  err_bits;
	logic [DEV_W-1:0]  abs_dev, least_upd;
	logic [TRIM_W-1:0] step_half, trial_srch, scan_lo_new, scan_hi_new, best_upd;
	logic [TRIM_W:0]   trial_ext;
	logic              scan_better, scan_end, fin_first, fin_restore;

	assign is_dual   = cfg.range_mode == MODE_DUAL;
	assign is_low    = cfg.range_mode == MODE_LOW;
	assign err_bits  = in_q.freq_error;
	assign err_zero  = err_bits == '0;
	assign err_neg   = err_bits[ERR_W-1];
	assign abs_dev   = err_neg ? (~err_bits + 16'd1) : err_bits;
	assign step_half = step_q >> 1;
	assign trial_srch = err_neg ? (trial_q - step_half) : (trial_q + step_half);
	assign trial_ext = {1'b0, trial_q};

	// scan window around the search result, clipped to the range
	assign scan_lo_new = (trial_ext > ({1'b0, scan_lo_q} + (TRIM_W+1)'(SCAN_SPAN)))
		? (trial_q - SCAN_SPAN) : scan_lo_q;
	assign scan_hi_new = ((trial_ext + (TRIM_W+1)'(SCAN_SPAN)) < {1'b0, scan_hi_q})
		? (trial_q + SCAN_SPAN) : scan_hi_q;

	// scan keeps the least deviation, later ties win
	assign scan_better = abs_dev <= least_q;
	assign least_upd   = scan_better ? abs_dev : least_q;
	assign best_upd    = scan_better ? trial_q : best_q;
	assign scan_end    = (trial_q >= scan_hi_q) || (trial_q == TRIM_MAX);

	// range completion choices
	assign fin_first   = is_dual && !ri_q;
	assign fin_restore = is_dual && ri_q && (frd_q < fdev_q);

	// range bounds for a new search
	logic [TRIM_W-1:0] rng_lo, rng_hi, rng_step, rng_trial;
	logic [TRIM_W:0]   rng_span;

	always_comb begin
		if (is_dual && ri_q) begin
			rng_lo = TRIM_MID;
			rng_hi = TRIM_MAX;
		end else if (is_dual || is_low) begin
			rng_lo = '0;
			rng_hi = TRIM_LOW_TOP;
		end else begin
			rng_lo = '0;
			rng_hi = TRIM_MAX;
		end
	end

	assign rng_span  = {1'b0, rng_hi} - {1'b0, rng_lo} + 9'd1;
	assign rng_step  = rng_span[TRIM_W:1];
	assign rng_trial = rng_lo + rng_step;

	// shared trim step unit
	logic [TRIM_W-1:0] ms, cross_t, wdiff, wstep, wnext;
	logic              setup_jump, w_at, w_up, w_land;

	assign ms = (cfg.max_step == '0) ? 8'd1 : cfg.max_step;

	// crossing the range edge heads for the own range's switch point first
	always_comb begin
		cross_t = worig_q;
		if (is_dual && !cur_q[TRIM_W-1] && worig_q[TRIM_W-1]) begin
			cross_t = TRIM_W'({1'b0, cfg.low_switch_point});
		end else if (is_dual && cur_q[TRIM_W-1] && !worig_q[TRIM_W-1]) begin
			cross_t = cfg.high_switch_point;
		end
	end

	assign setup_jump = (worig_q != cross_t) && (cur_q == cross_t);
	assign w_at       = cur_q == wtgt_q;
	assign w_up       = cur_q < wtgt_q;
	assign wdiff      = w_up ? (wtgt_q - cur_q) : (cur_q - wtgt_q);
	assign wstep      = (wdiff > ms) ? (w_up ? (cur_q + ms) : (cur_q - ms)) : wtgt_q;
	assign w_land     = (worig_q != wtgt_q) && (wstep == wtgt_q);
	assign wnext      = w_land ? mirror(cfg, wtgt_q) : wstep;

	// trim write issue
	logic              wr_now, wr_direct, wr_stall, wr_fire;
	logic [TRIM_W-1:0] wr_val;

	always_comb begin
		wr_now = 1'b0;
		wr_val = wnext;
		if (state_q == ST_WALK_SETUP && setup_jump) begin
			wr_now = 1'b1;
			wr_val = mirror(cfg, cross_t);
		end else if (state_q == ST_WALK && !w_at) begin
			wr_now = 1'b1;
		end
	end

	assign wr_direct = wcnt_q < WRITE_DIRECT;
	assign wr_stall  = wr_now && wr_direct && !res_ready;
	assign wr_fire   = wr_now && !wr_stall;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) begin
				state_d = ST_DECODE;
			end
			ST_DECODE: begin
				if (in_q.action == ACT_START) begin
					state_d = ST_BEGIN;
				end else if (phase_q == PH_IDLE) begin
					state_d = ST_IDLE;
				end else if (err_zero) begin
					state_d = ST_FINISH;
				end else begin
					state_d = ST_WALK_SETUP;
				end
			end
			ST_BEGIN: state_d = ST_WALK_SETUP;
			ST_FINISH: begin
				if (fin_first) begin
					state_d = ST_BEGIN;
				end else if (fin_restore) begin
					state_d = ST_WALK_SETUP;
				end else begin
					state_d = ST_FLUSH;
				end
			end
			ST_WALK_SETUP: if (!wr_stall) begin
				state_d = ST_WALK;
			end
			ST_WALK: if (w_at) begin
				state_d = (cont_q == CONT_FINISH) ? ST_FINISH : ST_FLUSH;
			end
			ST_FLUSH: if (!pend_v_q || res_ready) begin
				state_d = ST_FINAL;
			end
			ST_FINAL: if (res_ready) begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		res_valid               = 1'b0;
		res_item.kind           = KIND_WRITE;
		res_item.trim           = wr_val;
		res_item.best_deviation = '0;
		res_item.last           = 1'b0;
		unique case (state_q)
			ST_WALK_SETUP, ST_WALK: res_valid = wr_now && wr_direct;
			ST_FLUSH: begin
				res_valid     = pend_v_q;
				res_item.trim = pend_q;
			end
			ST_FINAL: begin
				res_valid               = 1'b1;
				res_item.kind           = fkind_q;
				res_item.trim           = cur_q;
				res_item.best_deviation = (fkind_q == KIND_DONE) ? fdev_q : '0;
				res_item.last           = 1'b1;
			end
			default: ;
		endcase
	end

	assign in_ready = state_q == ST_IDLE;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// captured input item
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			in_q <= in_item;
		end
	end

	// calibration state and walk registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			cont_q    <= CONT_MEAS;
			fkind_q   <= KIND_MEASURE;
			cur_q     <= '0;
			step_q    <= '0;
			trial_q   <= '0;
			scan_lo_q <= '0;
			scan_hi_q <= '0;
			best_q    <= '0;
			least_q   <= '1;
			ri_q      <= 1'b0;
			frt_q     <= '0;
			frd_q     <= '0;
			fdev_q    <= '0;
			wtgt_q    <= '0;
			worig_q   <= '0;
			pend_q    <= '0;
			pend_v_q  <= 1'b0;
			wcnt_q    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (in_valid) begin
					wcnt_q   <= '0;
					pend_v_q <= 1'b0;
				end
				ST_DECODE: begin
					if (in_q.action == ACT_START) begin
						cur_q   <= in_q.initial_trim;
						ri_q    <= 1'b0;
						frt_q   <= '0;
						frd_q   <= '0;
						least_q <= '1;
					end else if (phase_q != PH_IDLE) begin
						if (err_zero) begin
							fdev_q <= '0;
						end else if (phase_q == PH_SEARCH) begin
							step_q <= step_half;
							cont_q <= CONT_MEAS;
							if (step_half == '0) begin
								scan_lo_q <= scan_lo_new;
								scan_hi_q <= scan_hi_new;
								best_q    <= trial_q;
								least_q   <= DEV_MAX;
								trial_q   <= scan_lo_new;
								worig_q   <= scan_lo_new;
								phase_q   <= PH_SCAN;
							end else begin
								trial_q <= trial_srch;
								worig_q <= trial_srch;
							end
						end else begin
							least_q <= least_upd;
							best_q  <= best_upd;
							if (scan_end) begin
								worig_q <= best_upd;
								fdev_q  <= least_upd;
								cont_q  <= CONT_FINISH;
							end else begin
								trial_q <= trial_q + 8'd1;
								worig_q <= trial_q + 8'd1;
								cont_q  <= CONT_MEAS;
							end
						end
					end
				end
				ST_BEGIN: begin
					scan_lo_q <= rng_lo;
					scan_hi_q <= rng_hi;
					step_q    <= rng_step;
					trial_q   <= rng_trial;
					worig_q   <= rng_trial;
					phase_q   <= PH_SEARCH;
					cont_q    <= CONT_MEAS;
				end
				ST_FINISH: begin
					if (fin_first) begin
						frt_q <= cur_q;
						frd_q <= fdev_q;
						ri_q  <= 1'b1;
					end else begin
						phase_q <= PH_IDLE;
						if (fin_restore) begin
							fdev_q  <= frd_q;
							worig_q <= frt_q;
							cont_q  <= CONT_DONE;
						end else begin
							fkind_q <= KIND_DONE;
						end
					end
				end
				ST_WALK_SETUP: if (!wr_stall) begin
					wtgt_q <= setup_jump ? worig_q : cross_t;
				end
				ST_WALK: begin
					if (w_at) begin
						fkind_q <= (cont_q == CONT_DONE) ? KIND_DONE : KIND_MEASURE;
					end else if (!wr_stall) begin
						wtgt_q <= w_land ? worig_q : wtgt_q;
					end
				end
				default: ;
			endcase

			// every trim write moves the trim in force
			if (wr_fire) begin
				cur_q <= wr_val;
				if (wr_direct) begin
					wcnt_q <= wcnt_q + 5'd1;
				end else begin
					pend_q   <= wr_val;
					pend_v_q <= 1'b1;
				end
			end
		end
	end

	// write counter saturates at the direct limit
	assert property (@(posedge clk) disable iff (!arst_n)
		wcnt_q <= WRITE_DIRECT)
		else $error("write count past direct limit");

	// a held write exists only once the direct writes are used up
	assert property (@(posedge clk) disable iff (!arst_n)
		pend_v_q |-> wcnt_q == WRITE_DIRECT)
		else $error("held write before direct limit");

	// only the closing result of an item is other than a trim write
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_item.last) |-> res_item.kind == KIND_WRITE)
		else $error("non-write result without last");

	// an accepted item is decoded in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> state_q == ST_DECODE)
		else $error("accepted item not decoded");

	// scan window never inverts
	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_SCAN |-> scan_lo_q <= scan_hi_q)
		else $error("scan window inverted");

endmodule

`default_nettype wire

FILE: rtl/core/oscillator_trim_calibrator_unit.sv
// top level of the oscillator trim calibrator
//
// Usage: write range_mode, max_step and the two switch points over the
// apb-style port while the block is idle (pready is always high). Send a
// start item with the trim now in force; the block answers with trim writes
// and one measure request. Each measurement report then gives more trim
// writes followed by a measure request, or by a done result that carries
// the chosen trim and its absolute error. The closing result of every item
// has last set. A report while no calibration runs gives no result.
// An item goes through decode and setup, the trim writes of the stepped
// walk, and the closing result; a range change or final restore passes
// through a finish step and a new walk setup. The sequencer works on
// one item at a time, so the next item is taken once the closing result is
// in the output register. The walk unit steps the trim by max_step per
// cycle unless the receiver stalls. Writes past the thirtieth of one item
// collapse into a single write of the last trim, sent before the close.
// Reset returns the registers to their defaults and the block to idle.
// When the receiver stalls, the sequencer holds and no result is lost.
`default_nettype none

module oscillator_trim_calibrator_unit import otc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_item_t             out_data
);

	cfg_t      cfg;
	logic      res_valid, res_ready;
	out_item_t res_item;
	logic      out_valid_q;
	out_item_t out_q;

	// configuration registers
	otc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// calibration sequencer
	otc_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_item  (res_item)
	);

	// output register, refilled in the cycle it drains
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res_item;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

FILE: tb/otc_trim_checker.sv
// checker of the oscillator trim calibrator: tracks the settings, predicts every result, compares
`timescale 1ns / 100ps

module otc_trim_checker import otc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic                  pready,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  in_item_t              in_data,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  out_item_t             out_data,
	output int                    fail_count,
	output int                    checked,
	output int                    pending,
	output logic                  busy
);

	// copy of the register settings, follows the writes on the register port
	logic [1:0]        cfg_mode;
	logic [TRIM_W-1:0] cfg_step;
	logic [6:0]        cfg_low_sw;
	logic [TRIM_W-1:0] cfg_high_sw;

	// calibration state
	phase_t            calib_phase;
	logic [TRIM_W-1:0] trim_now;
	logic [TRIM_W-1:0] step_size;
	logic [TRIM_W-1:0] trial;
	logic [TRIM_W-1:0] lo_bound;
	logic [TRIM_W-1:0] hi_bound;
	logic [TRIM_W-1:0] best_trim;
	logic [16:0]       least_dev;
	logic              second_range;
	logic [TRIM_W-1:0] kept_trim;
	logic [16:0]       kept_dev;

	// trims written for the current item, and results still owed by the block
	logic [TRIM_W-1:0] trim_writes[$];
	out_item_t         owed_results[$];

	int errors;
	int results_seen;
	out_item_t want;

	assign fail_count = errors;
	assign checked    = results_seen;

	function automatic void owe(input kind_t kind, input logic [TRIM_W-1:0] trim,
			input logic [DEV_W-1:0] dev, input logic last);
		out_item_t r;
		r.kind           = kind;
		r.trim           = trim;
		r.best_deviation = dev;
		r.last           = last;
		owed_results.push_back(r);
	endfunction

	function automatic void note_write(input logic [TRIM_W-1:0] value);
		trim_now = value;
		trim_writes.push_back(value);
	endfunction

	// closing result of an item; long walks keep the first writes and the final one
	function automatic void close_item(input kind_t kind, input logic [16:0] dev);
		int n;
		int i;
		n = trim_writes.size();
		for (i = 0; i < n; i++)
			if (i < int'(WRITE_DIRECT) || i == n - 1)
				owe(KIND_WRITE, trim_writes[i], '0, 1'b0);
		owe(kind, trim_now, dev[DEV_W-1:0], 1'b1);
		trim_writes.delete();
	endfunction

	// stepped walk to a trim, with the switch-point jump in dual mode when the 0x80 edge is crossed
	function automatic void walk_to(input logic [TRIM_W-1:0] target);
		int orig;
		int t;
		int cur;
		int stp;
		orig = int'(target);
		t    = orig;
		cur  = int'(trim_now);
		stp  = (cfg_step == 0) ? 1 : int'(cfg_step);
		if (cfg_mode == MODE_DUAL) begin
			if (cur < 128 && t >= 128)
				t = int'(cfg_low_sw);
			else if (cur >= 128 && t < 128)
				t = int'(cfg_high_sw);
			// already sitting on the switch point: jump right away
			if (orig != t && cur == t) begin
				cur = (int'(cfg_low_sw) + int'(cfg_high_sw) - t) & 255;
				t   = orig;
				note_write(cur[7:0]);
			end
		end
		while (cur != t) begin
			if (cur < t)
				cur = (t - cur > stp) ? cur + stp : t;
			else
				cur = (cur - t > stp) ? cur - stp : t;
			if (orig != t && cur == t) begin
				cur = (int'(cfg_low_sw) + int'(cfg_high_sw) - t) & 255;
				t   = orig;
			end
			note_write(cur[7:0]);
		end
	endfunction

	// set the bounds of the range and walk to its middle
	function automatic void start_range();
		int span;
		if (cfg_mode == MODE_DUAL) begin
			lo_bound = second_range ? TRIM_MID : 8'h00;
			hi_bound = second_range ? TRIM_MAX : TRIM_LOW_TOP;
		end else if (cfg_mode == MODE_LOW) begin
			lo_bound = 8'h00;
			hi_bound = TRIM_LOW_TOP;
		end else begin
			lo_bound = 8'h00;
			hi_bound = TRIM_MAX;
		end
		span        = int'(hi_bound) - int'(lo_bound) + 1;
		step_size   = 8'(span / 2);
		trial       = lo_bound + step_size;
		calib_phase = PH_SEARCH;
		walk_to(trial);
		close_item(KIND_MEASURE, '0);
	endfunction

	// end of a range: move on to the upper half, or restore the better one and finish
	function automatic void end_range(input logic [16:0] dev);
		logic [16:0] chosen;
		chosen = dev;
		if (cfg_mode == MODE_DUAL && !second_range) begin
			kept_trim    = trim_now;
			kept_dev     = dev;
			second_range = 1'b1;
			start_range();
		end else begin
			if (cfg_mode == MODE_DUAL && kept_dev < dev) begin
				walk_to(kept_trim);
				chosen = kept_dev;
			end
			calib_phase = PH_IDLE;
			close_item(KIND_DONE, chosen);
		end
	endfunction

	function automatic void take_report(input logic signed [ERR_W-1:0] err);
		int t;
		int mag;
		logic [16:0] dev;
		if (calib_phase == PH_SEARCH) begin
			if (err == 0) begin
				end_range('0);
			end else begin
				step_size = step_size >> 1;
				if (step_size == 0) begin
					// halving done: scan the neighbors of the last trial
					t = int'(trial);
					if (t > int'(lo_bound) + 2)
						lo_bound = 8'(t - 2);
					if (t + 2 < int'(hi_bound))
						hi_bound = 8'(t + 2);
					best_trim   = trial;
					least_dev   = 17'h0ffff;
					trial       = lo_bound;
					calib_phase = PH_SCAN;
				end else if (err > 0) begin
					trial = trial + step_size;
				end else begin
					trial = trial - step_size;
				end
				walk_to(trial);
				close_item(KIND_MEASURE, '0);
			end
		end else if (calib_phase == PH_SCAN) begin
			if (err == 0) begin
				end_range('0);
			end else begin
				mag = (err < 0) ? -int'(err) : int'(err);
				dev = mag[16:0];
				// later trims win ties
				if (dev <= least_dev) begin
					least_dev = dev;
					best_trim = trial;
				end
				if (trial >= hi_bound || trial == TRIM_MAX) begin
					walk_to(best_trim);
					end_range(least_dev);
				end else begin
					trial = trial + 8'd1;
					walk_to(trial);
					close_item(KIND_MEASURE, '0);
				end
			end
		end
	endfunction

	function automatic void calibrate_item(input in_item_t item);
		if (item.action == ACT_START) begin
			trim_now     = item.initial_trim;
			second_range = 1'b0;
			kept_trim    = '0;
			kept_dev     = '0;
			least_dev    = 17'h1ffff;
			start_range();
		end else begin
			take_report(item.freq_error);
		end
	endfunction

	function automatic void check_field(input string name, input logic [31:0] exp_val,
			input logic [31:0] act_val);
		if (exp_val !== act_val) begin
			$error("%s: expected %0d, got %0d", name, exp_val, act_val);
			errors++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_mode     = RST_RANGE_MODE;
			cfg_step     = RST_MAX_STEP;
			cfg_low_sw   = RST_LOW_SWITCH;
			cfg_high_sw  = RST_HIGH_SWITCH;
			calib_phase  = PH_IDLE;
			trim_now     = '0;
			step_size    = '0;
			trial        = '0;
			lo_bound     = '0;
			hi_bound     = '0;
			best_trim    = '0;
			least_dev    = 17'h1ffff;
			second_range = 1'b0;
			kept_trim    = '0;
			kept_dev     = '0;
			trim_writes.delete();
			owed_results.delete();
			errors       = 0;
			results_seen = 0;
			pending <= 0;
			busy    <= 1'b0;
		end else begin
			// register writes
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_RANGE_MODE:  cfg_mode    = pwdata[1:0];
					REG_MAX_STEP:    cfg_step    = pwdata[7:0];
					REG_LOW_SWITCH:  cfg_low_sw  = pwdata[6:0];
					REG_HIGH_SWITCH: cfg_high_sw = pwdata[7:0];
					default: ;
				endcase
			end
			// accepted input item
			if (in_valid && in_ready)
				calibrate_item(in_data);
			// accepted result against the oldest owed one
			if (out_valid && out_ready) begin
				results_seen++;
				if (owed_results.size() == 0) begin
					$error("result with nothing owed: kind %0d trim %0d",
						out_data.kind, out_data.trim);
					errors++;
				end else begin
					want = owed_results.pop_front();
					check_field("kind", want.kind, out_data.kind);
					check_field("trim", want.trim, out_data.trim);
					check_field("best_deviation", want.best_deviation,
						out_data.best_deviation);
					check_field("last", want.last, out_data.last);
				end
			end
			pending <= owed_results.size();
			busy    <= (calib_phase != PH_IDLE);
		end
	end

endmodule

FILE: tb/tb_oscillator_trim_calibrator_unit.sv
// testbench top of the oscillator trim calibrator: stimulus, watchdog and verdict
`timescale 1ns / 100ps

module tb_oscillator_trim_calibrator_unit;
	import otc_pkg::*;

	localparam int         STALL_LIMIT = 4000;
	localparam logic [1:0] MODE_SPARE  = 2'd3;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  psel      = 1'b0;
	logic                  penable   = 1'b0;
	logic                  pwrite    = 1'b0;
	logic [APB_ADDR_W-1:0] paddr     = '0;
	logic [APB_DATA_W-1:0] pwdata    = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	in_item_t              in_data   = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	out_item_t             out_data;

	int   fail_count;
	int   checked;
	int   pending;
	logic busy;

	int send_gap_pct  = 31;
	int recv_gap_pct  = 66;
	int items_sent    = 0;
	int settings_used = 0;
	int stall_cycles  = 0;
	logic [6:0]        sw_low  = RST_LOW_SWITCH;
	logic [TRIM_W-1:0] sw_high = RST_HIGH_SWITCH;

	oscillator_trim_calibrator_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	otc_trim_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.pready     (pready),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.fail_count (fail_count),
		.checked    (checked),
		.pending    (pending),
		.busy       (busy)
	);

	always #6 clk = ~clk;

	// receiver stalls at random
	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_gap_pct);
	end

	// cycles since the last item moved on either channel
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		wait (stall_cycles >= STALL_LIMIT);
		$display("watchdog: nothing moved for %0d cycles, %0d results owed",
			STALL_LIMIT, pending);
		$display("== FAIL ==");
		$finish;
	end

	function automatic in_item_t start_item(input logic [TRIM_W-1:0] trim,
			input logic signed [ERR_W-1:0] err);
		in_item_t item;
		item.action       = ACT_START;
		item.initial_trim = trim;
		item.freq_error   = err;
		return item;
	endfunction

	function automatic in_item_t report_item(input logic signed [ERR_W-1:0] err);
		in_item_t item;
		item.action       = ACT_REPORT;
		item.initial_trim = 8'($urandom);
		item.freq_error   = err;
		return item;
	endfunction

	// mostly full-range errors, some tiny ones for ties, a few exact hits
	function automatic logic signed [ERR_W-1:0] random_error();
		int pick;
		pick = $urandom_range(0, 15);
		if (pick == 0)
			return '0;
		if (pick < 5)
			return 16'($urandom_range(0, 6) - 3);
		return 16'($urandom);
	endfunction

	function automatic logic [TRIM_W-1:0] random_trim();
		int pick;
		pick = $urandom_range(0, 7);
		if (pick == 0)
			return {1'b0, sw_low};
		if (pick == 1)
			return sw_high;
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic send_item(input in_item_t item, input bit counted);
		// sender and receiver idle rates change as the run goes on
		if (items_sent < 70) begin
			send_gap_pct = 31;
			recv_gap_pct = 66;
		end else if (items_sent < 140) begin
			send_gap_pct = 66;
			recv_gap_pct = 31;
		end else begin
			send_gap_pct = 0;
			recv_gap_pct = 0;
		end
		while ($urandom_range(0, 99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (counted)
			items_sent++;
	endtask

	// hold off until every owed result has come back
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic reg_write(input logic [1:0] idx, input logic [APB_DATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
	endtask

	task automatic apply_setting(input logic [1:0] mode, input logic [TRIM_W-1:0] step,
			input logic [6:0] low_sw, input logic [TRIM_W-1:0] high_sw);
		wait_drained();
		// close a calibration still open with exact reports
		while (busy) begin
			send_item(report_item('0), 1'b0);
			wait_drained();
		end
		repeat (16) @(posedge clk);
		reg_write(REG_RANGE_MODE, 32'(mode));
		reg_write(REG_MAX_STEP, 32'(step));
		reg_write(REG_LOW_SWITCH, 32'(low_sw));
		reg_write(REG_HIGH_SWITCH, 32'(high_sw));
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		sw_low  = low_sw;
		sw_high = high_sw;
		settings_used++;
	endtask

	// random calibrations, mostly complete, some cut short, some stray reports
	task automatic run_random(input int quota);
		int goal;
		int reports;
		goal = items_sent + quota;
		while (items_sent < goal) begin
			case ($urandom_range(0, 9))
				0: send_item(report_item(random_error()), 1'b0);
				1: begin
					send_item(start_item(random_trim(), random_error()), 1'b1);
					repeat ($urandom_range(1, 4))
						send_item(report_item(random_error()), 1'b1);
				end
				default: begin
					send_item(start_item(random_trim(), random_error()), 1'b1);
					send_item(report_item(random_error()), 1'b1);
					reports = 1;
					while (busy && reports < 40) begin
						send_item(report_item(random_error()), 1'b1);
						reports++;
					end
				end
			endcase
			if ($urandom_range(0, 7) == 0)
				wait_drained();
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// default settings: stray report, error extremes, restart, exact hit
		send_item(report_item(16'sh7fff), 1'b0);
		send_item(start_item(8'hff, 16'sh8000), 1'b1);
		send_item(report_item(16'sh8000), 1'b1);
		send_item(report_item(16'sh7fff), 1'b1);
		send_item(start_item(8'h00, 16'sh0000), 1'b1);
		send_item(report_item(16'sh0000), 1'b1);
		send_item(report_item(16'sh0001), 1'b0);

		// spare range mode, zero step: a walk far past the write limit
		apply_setting(MODE_SPARE, 8'd0, 7'd96, 8'd128);
		send_item(start_item(8'h00, 16'sh1234), 1'b1);
		send_item(report_item(16'sh0005), 1'b1);
		send_item(report_item(16'sh0000), 1'b1);

		// two ranges, starting on the high switch point
		apply_setting(MODE_DUAL, 8'd255, 7'd127, 8'd128);
		send_item(start_item(8'd128, 16'sh0000), 1'b1);
		send_item(report_item(16'sh0000), 1'b1);
		send_item(report_item(-16'sd7), 1'b1);
		send_item(report_item(16'sh0000), 1'b1);

		// low range, unit step from the top trim
		apply_setting(MODE_LOW, 8'd1, 7'd0, 8'd255);
		send_item(start_item(8'hff, 16'shffff), 1'b1);
		send_item(report_item(16'sh0000), 1'b1);

		apply_setting(MODE_FULL, 8'd32, 7'd96, 8'd128);
		run_random(30);
		apply_setting(MODE_DUAL, 8'd255, 7'd0, 8'd255);
		run_random(30);
		apply_setting(MODE_LOW, 8'd1, 7'd127, 8'd128);
		run_random(30);
		apply_setting(MODE_DUAL, 8'($urandom_range(1, 16)), 7'($urandom_range(0, 127)),
			8'($urandom_range(128, 255)));
		run_random(30);
		apply_setting(MODE_SPARE, 8'd255, 7'd64, 8'd192);
		run_random(30);
		apply_setting(MODE_DUAL, 8'd1, 7'd100, 8'd200);
		run_random(30);

		wait_drained();
		repeat (20) @(posedge clk);
		$display("run covered %0d items and %0d checked results over %0d register settings",
			items_sent, checked, settings_used);
		$display("modes full, low, dual and spare; steps 0 to 255; switch extremes and long walks");
		if (fail_count == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

FILE: sim.f
rtl/core/otc_pkg.sv
rtl/core/otc_regs.sv
rtl/core/otc_engine.sv
rtl/core/oscillator_trim_calibrator_unit.sv
tb/otc_trim_checker.sv
tb/tb_oscillator_trim_calibrator_unit.sv
